// File: sv/tpg_pkg.sv
// Shared constants, code values and the controller command bundle for the
// trapezoidal profile generator. No dependencies.
package tpg_pkg;

  localparam int POSITION_BITS  = 24;
  localparam int SPEED_BITS     = 16;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam int VEL_BITS      = SPEED_BITS + 1;
  localparam int SPD_CMP_BITS  = ((SPEED_BITS > CFG_BITS) ? SPEED_BITS : CFG_BITS) + 1;
  localparam int SUM_BITS      = ((POSITION_BITS > VEL_BITS) ? POSITION_BITS : VEL_BITS) + 1;
  localparam int DIVIDEND_BITS = 2 * SPEED_BITS;
  localparam int DIVISOR_BITS  = CFG_BITS + 1;
  localparam int QUOT_CMP_BITS =
    (DIVIDEND_BITS > POSITION_BITS) ? DIVIDEND_BITS : POSITION_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIVIDEND_BITS - 1);

  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_IDLE   = 2'd0;
  localparam phase_t PHASE_ACCEL  = 2'd1;
  localparam phase_t PHASE_CRUISE = 2'd2;
  localparam phase_t PHASE_DECEL  = 2'd3;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_MAX_VELOCITY     = 1'd0;
  localparam cfg_index_t REG_MAX_ACCELERATION = 1'd1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // One strobe per datapath step, issued by the controller.
  typedef struct packed {
    logic load;          // capture the accepted item
    logic target;        // resolve relative target, square the speed limit
    logic setup;         // direction and move length, load the divider
    logic div_step;      // one quotient bit
    logic ramp;          // saturate and store the ramp distance
    logic start_commit;  // commit start state and present its result
    logic tick_meas;     // distance travelled from the origin
    logic tick_speed;    // phase and new speed
    logic tick_commit;   // advance setpoint and present the result
  } tpg_cmd_t;

endpackage

// File: sv/trapezoidal_profile_generator.sv
// Trapezoidal profile generator, top level. Depends on tpg_pkg, tpg_ctrl, tpg_dpath.
// A tick item runs the measure, speed and commit steps. A start item runs the
// target, setup, divide, ramp and commit steps, the one-bit-per-cycle restoring
// divider forming the ramp distance. One item is in work at a time; a new item
// is accepted only once the last one has committed its result.
// Reset (synchronous, rst_n low) clears all move state, drops out_valid, and sets
// max_velocity to 0 and max_acceleration to 1.
//
// Structure: tpg_ctrl sequences each item through the datapath steps and owns
// both handshakes; tpg_dpath holds the configuration registers, the move state
// (origin, ramp distance, braking point, direction, speed, commanded position)
// and a registered output stage. The next item may be accepted while a result
// still waits on out_stall; its own result is then held back until the output
// register is free. A start item resolves the target (saturating a relative
// offset), squares the speed limit, works out direction and move length, divides
// v*v by 2a, and commits with setpoint equal to the origin. A tick item measures
// the distance travelled from the origin, chooses decelerate, accelerate or
// cruise, clamps the speed to the limit and advances the setpoint with
// saturation. The configuration port is always ready; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module trapezoidal_profile_generator (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_command,
  input  logic                                     in_relative,
  input  logic signed [tpg_pkg::POSITION_BITS-1:0] in_target_position,
  input  logic signed [tpg_pkg::POSITION_BITS-1:0] in_current_position,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [tpg_pkg::POSITION_BITS-1:0] out_setpoint,
  output logic signed [tpg_pkg::VEL_BITS-1:0]      out_velocity,
  output logic [1:0]                               out_phase,
  output logic                                     out_finished,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [tpg_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [tpg_pkg::CFG_BITS-1:0]             cfg_data
);
  import tpg_pkg::*;

  tpg_cmd_t cmd;
  logic     cfg_we;

  // Register writes never wait, so the port never pushes back.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd)
  );

  tpg_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_relative         (in_relative),
    .in_target_position  (in_target_position),
    .in_current_position (in_current_position),
    .out_setpoint        (out_setpoint),
    .out_velocity        (out_velocity),
    .out_phase           (out_phase),
    .out_finished        (out_finished)
  );

endmodule

// File: sv/tpg_div.sv
// Restoring divider, one quotient bit per step, for the ramp distance.
// Depends on tpg_pkg.
module tpg_div (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               step,
  input  logic [tpg_pkg::DIVIDEND_BITS-1:0]  dividend,
  input  logic [tpg_pkg::DIVISOR_BITS-1:0]   divisor,
  output logic [tpg_pkg::DIVIDEND_BITS-1:0]  quotient
);
  import tpg_pkg::*;

  logic [DIVIDEND_BITS-1:0] quo_r, quo_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0]  dsr_r;
  logic [DIVISOR_BITS:0]    rem_sh;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  // The dividend shifts out of the top of quo_r as quotient bits enter below.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVIDEND_BITS-1]};
    diff    = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
    quo_nxt = {quo_r[DIVIDEND_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

// File: sv/tpg_ctrl.sv
// Sequencing state machine of the profile generator: input handshake,
// divider iteration count and result valid. Depends on tpg_pkg.
module tpg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tpg_pkg::tpg_cmd_t cmd
);
  import tpg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TARGET, ST_SETUP, ST_DIVIDE, ST_RAMP, ST_START_DONE,
    ST_MEASURE, ST_SPEED, ST_TICK_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    accept;
  logic                    out_free;

  // Input is held off while an item is in work and during reset.
  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = (in_command == CMD_TICK) ? ST_MEASURE : ST_TARGET;
        end
      end
      ST_TARGET: begin
        cmd.target = 1'b1;
        state_nxt  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = DIV_LAST;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_RAMP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_RAMP: begin
        cmd.ramp  = 1'b1;
        state_nxt = ST_START_DONE;
      end
      ST_START_DONE: begin
        if (out_free) begin
          cmd.start_commit = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_MEASURE: begin
        cmd.tick_meas = 1'b1;
        state_nxt     = ST_SPEED;
      end
      ST_SPEED: begin
        cmd.tick_speed = 1'b1;
        state_nxt      = ST_TICK_DONE;
      end
      ST_TICK_DONE: begin
        if (out_free) begin
          cmd.tick_commit = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is never written over one that is still held back.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_commit || cmd.tick_commit) |-> !(out_valid_r && out_stall))
    else $error("result committed while output stalled");

  // Only one datapath step at a time.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.target, cmd.setup, cmd.div_step, cmd.ramp, cmd.start_commit,
              cmd.tick_meas, cmd.tick_speed, cmd.tick_commit}))
    else $error("several datapath steps at once");

  // An accepted item blocks further input on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accept");

  // Valid only rises because a result was committed.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.start_commit || cmd.tick_commit))
    else $error("output valid without a committed result");

endmodule

// File: sv/tpg_dpath.sv
// Datapath of the profile generator: configuration registers, move state,
// speed and setpoint arithmetic and output registers. Depends on tpg_pkg, tpg_div.
module tpg_dpath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  tpg_pkg::tpg_cmd_t                       cmd,
  input  logic                                    cfg_we,
  input  tpg_pkg::cfg_index_t                     cfg_index,
  input  logic [tpg_pkg::CFG_BITS-1:0]            cfg_data,
  input  logic                                    in_relative,
  input  logic signed [tpg_pkg::POSITION_BITS-1:0] in_target_position,
  input  logic signed [tpg_pkg::POSITION_BITS-1:0] in_current_position,
  output logic signed [tpg_pkg::POSITION_BITS-1:0] out_setpoint,
  output logic signed [tpg_pkg::VEL_BITS-1:0]      out_velocity,
  output tpg_pkg::phase_t                         out_phase,
  output logic                                    out_finished
);
  import tpg_pkg::*;

  localparam logic [SPD_CMP_BITS-1:0]  SPD_MAX_CMP  = SPD_CMP_BITS'({SPEED_BITS{1'b1}});
  localparam logic [QUOT_CMP_BITS-1:0] RAMP_MAX_CMP = QUOT_CMP_BITS'({POSITION_BITS{1'b1}});

  function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [SUM_BITS-1:0] v);
    logic ovf;
    ovf = (v[SUM_BITS-1:POSITION_BITS-1] !=
           {(SUM_BITS-POSITION_BITS+1){v[SUM_BITS-1]}});
    if (!ovf) begin
      sat_pos = v[POSITION_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      sat_pos = {1'b1, {(POSITION_BITS-1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(POSITION_BITS-1){1'b1}}};
    end
  endfunction

  // Configuration.
  logic [CFG_BITS-1:0] cfg_vmax_r, cfg_acc_r;

  // Captured item and working values.
  logic                             rel_r;
  logic signed [POSITION_BITS-1:0]  tgt_r, org_r;
  logic [DIVIDEND_BITS-1:0]         prod_r;
  logic [POSITION_BITS-1:0]         move_r, trav_r;
  logic [SPEED_BITS-1:0]            spd_new_r;
  phase_t                           phase_r;

  // Move state.
  logic signed [POSITION_BITS-1:0]  start_point_r, cmd_pos_r;
  logic [POSITION_BITS-1:0]         ramp_r, brake_r;
  logic                             heading_neg_r;
  logic [SPEED_BITS-1:0]            speed_r;

  // Output registers.
  logic signed [POSITION_BITS-1:0]  out_setpoint_r;
  logic signed [VEL_BITS-1:0]       out_velocity_r;
  phase_t                           out_phase_r;
  logic                             out_finished_r;

  logic [SPD_CMP_BITS-1:0]          vmax_cmp;
  logic [SPEED_BITS-1:0]            vmax_eff;
  logic [CFG_BITS-1:0]              acc_eff;
  logic signed [POSITION_BITS:0]    rel_sum, span_d, trav_d;
  logic [POSITION_BITS:0]           dist_abs, trav_abs;
  logic [DIVIDEND_BITS-1:0]         quotient;
  logic [QUOT_CMP_BITS-1:0]         quot_cmp;
  logic [POSITION_BITS-1:0]         ramp_sat, half, brake_nxt;
  logic [SPD_CMP_BITS-1:0]          spd_w, acc_w, spd_calc;
  phase_t                           phase_calc;
  logic signed [VEL_BITS-1:0]       vel_mag, vel;
  logic signed [SUM_BITS-1:0]       tick_sum;

  always_comb begin
    vmax_cmp = SPD_CMP_BITS'(cfg_vmax_r);
    vmax_eff = (vmax_cmp > SPD_MAX_CMP) ? {SPEED_BITS{1'b1}} : vmax_cmp[SPEED_BITS-1:0];
    acc_eff  = (cfg_acc_r == '0) ? CFG_BITS'(1) : cfg_acc_r;

    rel_sum  = {org_r[POSITION_BITS-1], org_r} + {tgt_r[POSITION_BITS-1], tgt_r};
    span_d   = {tgt_r[POSITION_BITS-1], tgt_r} - {org_r[POSITION_BITS-1], org_r};
    dist_abs = span_d[POSITION_BITS] ? -span_d : span_d;

    quot_cmp = QUOT_CMP_BITS'(quotient);
    ramp_sat = (quot_cmp > RAMP_MAX_CMP) ? {POSITION_BITS{1'b1}}
                                         : quot_cmp[POSITION_BITS-1:0];

    // Braking starts at half the move on a short move, else one ramp
    // before the end.
    half      = move_r >> 1;
    brake_nxt = (half < ramp_r) ? half : (move_r - ramp_r);

    trav_d   = {cmd_pos_r[POSITION_BITS-1], cmd_pos_r}
             - {start_point_r[POSITION_BITS-1], start_point_r};
    trav_abs = trav_d[POSITION_BITS] ? -trav_d : trav_d;

    // Deceleration is tested first, so a short move becomes a triangle.
    spd_w = SPD_CMP_BITS'(speed_r);
    acc_w = SPD_CMP_BITS'(cfg_acc_r);
    if (trav_r >= brake_r) begin
      phase_calc = PHASE_DECEL;
      spd_calc   = (spd_w > acc_w) ? (spd_w - acc_w) : '0;
    end else if (trav_r < ramp_r) begin
      phase_calc = PHASE_ACCEL;
      spd_calc   = spd_w + acc_w;
    end else begin
      phase_calc = PHASE_CRUISE;
      spd_calc   = spd_w;
    end
    if (spd_calc > SPD_CMP_BITS'(vmax_eff)) begin
      spd_calc = SPD_CMP_BITS'(vmax_eff);
    end

    vel_mag  = {1'b0, spd_new_r};
    vel      = heading_neg_r ? -vel_mag : vel_mag;
    tick_sum = SUM_BITS'(cmd_pos_r) + SUM_BITS'(vel);
  end

  tpg_div u_div (
    .clk      (clk),
    .load     (cmd.setup),
    .step     (cmd.div_step),
    .dividend (prod_r),
    .divisor  ({acc_eff, 1'b0}),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_vmax_r <= '0;
      cfg_acc_r  <= CFG_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_VELOCITY:     cfg_vmax_r <= cfg_data;
        REG_MAX_ACCELERATION: cfg_acc_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_point_r <= '0;
      cmd_pos_r     <= '0;
      ramp_r        <= '0;
      brake_r       <= '0;
      heading_neg_r <= 1'b0;
      speed_r       <= '0;
    end else begin
      if (cmd.setup) begin
        heading_neg_r <= span_d[POSITION_BITS] || (span_d == '0);
      end
      if (cmd.ramp) begin
        ramp_r <= ramp_sat;
      end
      if (cmd.start_commit) begin
        start_point_r <= org_r;
        cmd_pos_r     <= org_r;
        brake_r       <= brake_nxt;
        speed_r       <= '0;
      end
      if (cmd.tick_commit) begin
        speed_r   <= spd_new_r;
        cmd_pos_r <= sat_pos(tick_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rel_r <= in_relative;
      tgt_r <= in_target_position;
      org_r <= in_current_position;
    end
    if (cmd.target) begin
      if (rel_r) begin
        tgt_r <= sat_pos(SUM_BITS'(rel_sum));
      end
      prod_r <= vmax_eff * vmax_eff;
    end
    if (cmd.setup) begin
      move_r <= dist_abs[POSITION_BITS-1:0];
    end
    if (cmd.tick_meas) begin
      trav_r <= trav_abs[POSITION_BITS-1:0];
    end
    if (cmd.tick_speed) begin
      phase_r   <= phase_calc;
      spd_new_r <= spd_calc[SPEED_BITS-1:0];
    end
    if (cmd.start_commit) begin
      out_setpoint_r <= org_r;
      out_velocity_r <= '0;
      out_phase_r    <= PHASE_IDLE;
      out_finished_r <= 1'b0;
    end
    if (cmd.tick_commit) begin
      out_setpoint_r <= sat_pos(tick_sum);
      out_velocity_r <= vel;
      out_phase_r    <= phase_r;
      out_finished_r <= (phase_r == PHASE_DECEL) && (spd_new_r == '0);
    end
  end

  assign out_setpoint = out_setpoint_r;
  assign out_velocity = out_velocity_r;
  assign out_phase    = out_phase_r;
  assign out_finished = out_finished_r;

endmodule

// File: verif/trapezoidal_profile_generator_test.sv
// Self-checking testbench for the trapezoidal profile generator: directed moves, back-pressure
// and long runs of random moves, each result checked against an in-bench model of the profile.
// Depends on tpg_pkg and the trapezoidal_profile_generator RTL only.
module trapezoidal_profile_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpg_pkg::*;

  localparam longint POS_MAX     = (longint'(1) <<< (POSITION_BITS - 1)) - 1;
  localparam longint POS_MIN     = -POS_MAX - 1;
  localparam longint POS_SPAN    = (longint'(1) <<< POSITION_BITS) - 1;
  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     HOLD_LEN    = 300;
  // A start item is the slowest: the ramp divider takes one cycle per quotient bit.
  localparam int     SETTLE      = 2 * SPEED_BITS + 8;

  typedef struct {
    logic signed [POSITION_BITS-1:0] setpoint;
    logic signed [VEL_BITS-1:0]      velocity;
    phase_t                          phase;
    logic                            finished;
  } profile_result_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_command = CMD_START;
  logic                            in_relative = 1'b0;
  logic signed [POSITION_BITS-1:0] in_target_position = '0;
  logic signed [POSITION_BITS-1:0] in_current_position = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [POSITION_BITS-1:0] out_setpoint;
  logic signed [VEL_BITS-1:0]      out_velocity;
  logic [1:0]                      out_phase;
  logic                            out_finished;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [CFG_INDEX_BITS-1:0]       cfg_index = '0;
  logic [CFG_BITS-1:0]             cfg_data = '0;

  trapezoidal_profile_generator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_relative         (in_relative),
    .in_target_position  (in_target_position),
    .in_current_position (in_current_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_setpoint        (out_setpoint),
    .out_velocity        (out_velocity),
    .out_phase           (out_phase),
    .out_finished        (out_finished),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Profile state as the block should hold it. All distances and speeds are kept as
  // plain 64-bit integers so that no intermediate sum can wrap before it is clipped.
  longint move_origin      = 0;
  longint ramp_len         = 0;
  longint brake_point      = 0;
  bit     moving_negative  = 1'b0;
  longint speed_mag        = 0;
  longint position_cmd     = 0;
  longint cfg_max_velocity = 0;
  longint cfg_max_accel    = 1;
  bit     profile_finished = 1'b0;

  profile_result_t pending_results[$];

  int  items_sent      = 0;
  int  results_seen    = 0;
  int  mismatch_count  = 0;
  int  register_writes = 0;
  int  cycle_count     = 0;
  bit  sender_idles    = 1'b1;
  bit  receiver_idles  = 1'b1;
  int  holds_requested = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip_position(longint value);
    if (value > POS_MAX) return POS_MAX;
    if (value < POS_MIN) return POS_MIN;
    return value;
  endfunction

  // Advances the profile by one accepted item and queues the result it should produce.
  function automatic void predict_profile(bit cmd, bit rel, logic [POSITION_BITS-1:0] tgt,
                                          logic [POSITION_BITS-1:0] cur);
    profile_result_t want;
    longint          goal;
    longint          move_len;
    longint          travel;
    longint          accel;
    longint          vel;
    phase_t          ph;
    want.finished = 1'b0;
    if (cmd == CMD_START) begin
      goal = longint'($signed(tgt));
      move_origin = longint'($signed(cur));
      // The divider never sees a zero acceleration; the tick path uses the register as is.
      accel = (cfg_max_accel == 0) ? 1 : cfg_max_accel;
      if (rel) goal = clip_position(move_origin + goal);
      // A move of zero length counts as heading negative.
      moving_negative = !(goal > move_origin);
      move_len = goal - move_origin;
      if (move_len < 0) move_len = -move_len;
      ramp_len = (cfg_max_velocity * cfg_max_velocity) / (2 * accel);
      if (ramp_len > POS_SPAN) ramp_len = POS_SPAN;
      // A short move brakes at its midpoint and so never cruises.
      brake_point = (move_len / 2 < ramp_len) ? move_len / 2 : move_len - ramp_len;
      speed_mag = 0;
      position_cmd = move_origin;
      profile_finished = 1'b0;
      ph = PHASE_IDLE;
      vel = 0;
    end else begin
      travel = position_cmd - move_origin;
      if (travel < 0) travel = -travel;
      accel = cfg_max_accel;
      // Braking is tested before the ramp, so braking wins where the two overlap.
      if (travel >= brake_point) begin
        ph = PHASE_DECEL;
        speed_mag = (speed_mag > accel) ? speed_mag - accel : 0;
      end else if (travel < ramp_len) begin
        ph = PHASE_ACCEL;
        speed_mag = speed_mag + accel;
      end else begin
        ph = PHASE_CRUISE;
      end
      if (speed_mag > cfg_max_velocity) speed_mag = cfg_max_velocity;
      vel = moving_negative ? -speed_mag : speed_mag;
      position_cmd = clip_position(position_cmd + vel);
      want.finished = (ph == PHASE_DECEL) && (speed_mag == 0);
      profile_finished = want.finished;
    end
    want.setpoint = position_cmd[POSITION_BITS-1:0];
    want.velocity = vel[VEL_BITS-1:0];
    want.phase = ph;
    pending_results.push_back(want);
  endfunction

  // Offers one item, holds it until the block takes it, then may leave a random gap.
  task automatic send_item(bit cmd, bit rel, logic [POSITION_BITS-1:0] tgt,
                           logic [POSITION_BITS-1:0] cur);
    int gap;
    int pick;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_relative <= rel;
    in_target_position <= tgt;
    in_current_position <= cur;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_profile(cmd, rel, tgt, cur);
    items_sent++;
    gap = 0;
    if (sender_idles) begin
      pick = $urandom_range(0, 99);
      if (pick >= 96) gap = $urandom_range(10, 40);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A tick ignores the position fields, so they carry random noise.
  task automatic send_tick();
    send_item(CMD_TICK, 1'($urandom_range(0, 1)), POSITION_BITS'($urandom),
              POSITION_BITS'($urandom));
  endtask

  task automatic write_register(cfg_index_t idx, longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_BITS'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_MAX_VELOCITY) cfg_max_velocity = value;
    else cfg_max_accel = value;
    register_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering items and waits until every queued result has been checked, then
  // gives the block time to settle so that a register write finds it idle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The reset state itself, a move of zero length and a zero speed limit.
  task automatic test_reset_defaults();
    // With everything cleared the braking point is zero, so a bare tick finishes at once.
    send_tick();
    send_item(CMD_START, 1'b0, POSITION_BITS'(POS_MIN), POSITION_BITS'(POS_MIN));
    send_tick();
    // A zero speed limit: the profile cruises at zero speed and never gets anywhere.
    send_item(CMD_START, 1'b1, POSITION_BITS'(5000), POSITION_BITS'(1234));
    send_tick();
    wait_for_results();
  endtask

  // Extremes of both registers: setpoint overshoot past the range, relative targets that
  // saturate, a ramp too long to store, and a move cut short by a fresh start.
  task automatic test_saturation();
    write_register(REG_MAX_VELOCITY, 65535);
    write_register(REG_MAX_ACCELERATION, 65535);
    send_item(CMD_START, 1'b0, POSITION_BITS'(POS_MAX), POSITION_BITS'(POS_MAX - 100));
    repeat (3) send_tick();
    send_item(CMD_START, 1'b1, POSITION_BITS'(POS_MIN), POSITION_BITS'(POS_MIN + 100));
    repeat (2) send_tick();
    wait_for_results();
    write_register(REG_MAX_ACCELERATION, 1);
    send_item(CMD_START, 1'b1, POSITION_BITS'(POS_MAX), POSITION_BITS'(0));
    repeat (3) send_tick();
    send_item(CMD_START, 1'b1, POSITION_BITS'(7), POSITION_BITS'(-5));
    repeat (2) send_tick();
    wait_for_results();
  endtask

  // A small move in the negative direction, run through to the end.
  task automatic test_short_move();
    write_register(REG_MAX_VELOCITY, 3);
    write_register(REG_MAX_ACCELERATION, 2);
    send_item(CMD_START, 1'b1, POSITION_BITS'(-9), POSITION_BITS'(100));
    repeat (5) send_tick();
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the block
  // fills and stalls its input; then the sender waits for every result.
  task automatic test_output_hold_off();
    sender_idles = 1'b0;
    holds_requested++;
    send_item(CMD_START, 1'b1, POSITION_BITS'(40), POSITION_BITS'($urandom));
    repeat (14) send_tick();
    wait_for_results();
    sender_idles = 1'b1;
  endtask

  // One move with random origin, direction and length, mostly run until it finishes.
  task automatic run_random_move();
    longint origin;
    longint reach;
    longint goal;
    bit     rel;
    int     budget;
    int     pick;
    logic [POSITION_BITS-1:0] target_bits;
    pick = $urandom_range(0, 99);
    if (pick < 10) origin = POS_MAX - $urandom_range(0, 2000);
    else if (pick < 20) origin = POS_MIN + $urandom_range(0, 2000);
    else origin = longint'($signed(POSITION_BITS'($urandom)));
    // Long enough for both ramps and some cruising, short enough to finish in a few dozen ticks.
    reach = (cfg_max_velocity * cfg_max_velocity) / cfg_max_accel
            + cfg_max_velocity * $urandom_range(0, 30) + $urandom_range(0, 4);
    if (reach > POS_SPAN) reach = POS_SPAN;
    if ($urandom_range(0, 1) == 1) reach = -reach;
    rel = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) goal = longint'($urandom);
    else if (rel) goal = clip_position(reach);
    else goal = clip_position(origin + reach);
    target_bits = goal[POSITION_BITS-1:0];
    send_item(CMD_START, rel, target_bits, origin[POSITION_BITS-1:0]);
    // Now and then the move is broken off early by the next start.
    budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 150;
    for (int n = 0; n < budget && !profile_finished; n++) send_tick();
    if (profile_finished) repeat ($urandom_range(0, 3)) send_tick();
  endtask

  task automatic test_random_profiles();
    int     phase_end;
    longint vel_limit;
    longint accel;
    for (int p = 0; p < 12; p++) begin
      wait_for_results();
      if (p == 0) begin
        vel_limit = 65535;
        accel = 65535;
      end else if (p == 1) begin
        vel_limit = 2;
        accel = 1;
      end else begin
        vel_limit = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 300)
                                                : $urandom_range(2, 65535);
        accel = $urandom_range(vel_limit / 20 > 1 ? vel_limit / 20 : 1, vel_limit);
      end
      write_register(REG_MAX_VELOCITY, vel_limit);
      write_register(REG_MAX_ACCELERATION, accel);
      // Some phases run with one side never idling.
      receiver_idles = (p % 4 != 3);
      sender_idles = (p % 4 != 2);
      phase_end = items_sent + 125;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 19) == 0)
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    POSITION_BITS'($urandom), POSITION_BITS'($urandom));
        else
          run_random_move();
      end
    end
    receiver_idles = 1'b1;
    sender_idles = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_saturation();
    test_short_move();
    test_output_hold_off();
    test_random_profiles();
    wait_for_results();
    $display("Checked %0d results from %0d items over %0d register writes,",
             results_seen, items_sent, register_writes);
    $display("with long and short stalls on both sides and one long output hold-off.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** trapezoidal_profile_generator: PASSED **");
    end else begin
      $display("** trapezoidal_profile_generator: FAILED **");
    end
    $finish;
  end

  // Receiver side: random stall runs, most short and a few long, plus the long hold-off
  // that a test can ask for. The hold-off length is counted here, not by the test.
  int hold_left = 0;
  int run_left = 0;
  int holds_granted = 0;
  always @(posedge clk) begin
    int pick;
    if (holds_granted != holds_requested) begin
      holds_granted++;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
    end else if (!receiver_idles) begin
      out_stall <= 1'b0;
      run_left = 16;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 8);
      end else if (pick < 95) begin
        out_stall <= 1'b1;
        run_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        run_left = $urandom_range(10, 50);
      end
    end
  end

  // Every result taken from the block is compared with the oldest prediction.
  always @(posedge clk) begin
    profile_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %0d: setpoint %0d velocity %0d phase %0d finished %0b",
                   results_seen, out_setpoint, out_velocity, out_phase, out_finished);
      end else begin
        want = pending_results.pop_front();
        if (out_setpoint !== want.setpoint || out_velocity !== want.velocity ||
            out_phase !== want.phase || out_finished !== want.finished) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d: expected setpoint %0d velocity %0d phase %0d finished %0b,",
                      " got setpoint %0d velocity %0d phase %0d finished %0b"},
                     results_seen, want.setpoint, want.velocity, want.phase, want.finished,
                     out_setpoint, out_velocity, out_phase, out_finished);
        end
      end
    end
  end

  // Watchdog: a block that hangs or loses a result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("** trapezoidal_profile_generator: FAILED **");
      $finish;
    end
  end

endmodule

// File: trapezoidal_profile_generator.f
sv/tpg_pkg.sv
sv/tpg_div.sv
sv/tpg_ctrl.sv
sv/tpg_dpath.sv
sv/trapezoidal_profile_generator.sv
verif/trapezoidal_profile_generator_test.sv
